// ===== src/cache_block_word_mixer_core_macros.svh =====
// Assertion helpers shared by the mixer RTL.
`ifndef CACHE_BLOCK_WORD_MIXER_CORE_MACROS_SVH
`define CACHE_BLOCK_WORD_MIXER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBWM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cbwm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbwm_pkg
// Types, constants and helpers for the cache block word mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbwm_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned WORDS    = 8;
  localparam int unsigned ROUNDS   = 3;
  localparam int unsigned BLK_W    = 42;
  localparam int unsigned CFG_W    = 48;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [CFG_W-1:0]  cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CACHE_BYTES   = 2'd0,
    CFG_DATASET_BYTES = 2'd1,
    CFG_ROUND_COUNT   = 2'd2,
    CFG_TAP_COUNT     = 2'd3
  } cfg_idx_t;

  localparam word_t MIX_K0 = 64'h9e3779b97f4a7c15;
  localparam word_t MIX_K1 = 64'hd6e8feb86659fd93;
  localparam word_t MIX_K2 = 64'ha0761d6478bd642f;
  localparam word_t MUL_K  = MIX_K1 | 64'd1;

  typedef struct packed {
    word_t root_word_0;
    word_t root_word_1;
    word_t root_word_2;
    word_t root_word_3;
    word_t root_word_4;
    word_t root_word_5;
    word_t root_word_6;
    word_t root_word_7;
    blk_t  block_number;
  } in_item_t;

  typedef struct packed {
    word_t out_word_0;
    word_t out_word_1;
    word_t out_word_2;
    word_t out_word_3;
    word_t out_word_4;
    word_t out_word_5;
    word_t out_word_6;
    word_t out_word_7;
  } out_item_t;

  // Working set carried from cell to cell.
  typedef struct packed {
    word_t [WORDS-1:0] w;
    word_t             base;
    word_t             bias;
  } stage_t;

  function automatic word_t rotl(word_t v, logic [5:0] s);
    word_t res;
    if (s == 6'd0) begin
      res = v;
    end else begin
      res = (v << s) | (v >> (7'd64 - {1'b0, s}));
    end
    return res;
  endfunction

endpackage

// ===== src/cbwm_tweak.sv =====
// ----------------------------------------------------------------------------
// cbwm_tweak
// Forms the block base and XORs each root word with its rotated tweak.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbwm_tweak (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vin,
  input  cbwm_pkg::in_item_t din,
  input  cbwm_pkg::word_t   bias,
  output logic              vout,
  output cbwm_pkg::stage_t  dout
);
  import cbwm_pkg::*;

  logic              v1_r, v2_r, v3_r;
  word_t [WORDS-1:0] w1_r, w2_r;
  word_t             bias1_r, bias2_r;
  word_t             plo1_r;
  logic [31:0]       phi1_r;
  word_t             base2_r;
  stage_t            d3_r;
  stage_t            d3_nxt;

  // stage 1: split block index product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= vin;
    end
    w1_r[0] <= din.root_word_0;
    w1_r[1] <= din.root_word_1;
    w1_r[2] <= din.root_word_2;
    w1_r[3] <= din.root_word_3;
    w1_r[4] <= din.root_word_4;
    w1_r[5] <= din.root_word_5;
    w1_r[6] <= din.root_word_6;
    w1_r[7] <= din.root_word_7;
    bias1_r <= bias;
    plo1_r  <= {32'd0, din.block_number[31:0]} * {32'd0, MIX_K0[31:0]}
               + {32'(din.block_number[31:0] * MIX_K0[63:32]), 32'd0};
    phi1_r  <= 32'({22'd0, din.block_number[41:32]} * MIX_K0[31:0]);
  end

  // stage 2: base
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    w2_r    <= w1_r;
    bias2_r <= bias1_r;
    base2_r <= bias1_r + plo1_r + {phi1_r, 32'd0};
  end

  always_comb begin
    d3_nxt.base = base2_r;
    d3_nxt.bias = bias2_r;
    for (int i = 0; i < WORDS; i++) begin
      d3_nxt.w[i] = w2_r[i] ^ rotl(base2_r + word_t'(i) * MIX_K2,
                                   6'((9 * i + 17) % 64));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    d3_r <= d3_nxt;
  end

  assign vout = v3_r;
  assign dout = d3_r;

endmodule

// ===== src/cbwm_cell.sv =====
// ----------------------------------------------------------------------------
// cbwm_cell
// One word update of one round, four register stages deep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbwm_cell #(
  parameter int unsigned ROUND = 0,
  parameter int unsigned IDX   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vin,
  input  cbwm_pkg::stage_t din,
  output logic             vout,
  output cbwm_pkg::stage_t dout
);
  import cbwm_pkg::*;

  localparam int unsigned I1 = (IDX + 1) % WORDS;
  localparam int unsigned I3 = (IDX + 3) % WORDS;
  localparam int unsigned I5 = (IDX + 5) % WORDS;
  localparam logic [5:0]  A1 = 6'((7 * IDX + 11 * ROUND) % 64);
  localparam logic [5:0]  A2 = 6'((13 + IDX + ROUND) % 64);
  localparam logic [5:0]  A3 = 6'((19 + 3 * IDX + ROUND) % 64);
  localparam word_t       TC = word_t'(ROUND) * MIX_K1 + word_t'(IDX) * MIX_K2;

  logic        v1_r, v2_r, v3_r, v4_r;
  stage_t      d1_r, d2_r, d3_r, d4_r;
  word_t       s1_r, y1_r, x2_r, p0_r;
  logic [31:0] p1_r, p2_r;
  stage_t      d4_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= vin;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    // neighbor sum and bias term
    d1_r <= din;
    s1_r <= din.w[I1] + din.base + TC;
    y1_r <= din.w[I3] ^ rotl(din.bias, A2);
    // pre-multiply value
    d2_r <= d1_r;
    x2_r <= (d1_r.w[IDX] ^ rotl(s1_r, A1)) + y1_r;
    // partial products of the low 64 bits
    d3_r <= d2_r;
    p0_r <= {32'd0, x2_r[31:0]} * {32'd0, MUL_K[31:0]};
    p1_r <= 32'(x2_r[63:32] * MUL_K[31:0]);
    p2_r <= 32'(x2_r[31:0] * MUL_K[63:32]);
    d4_r <= d4_nxt;
  end

  always_comb begin
    d4_nxt = d3_r;
    d4_nxt.w[IDX] = (p0_r + {p1_r + p2_r, 32'd0}) ^ rotl(d3_r.w[I5], A3);
  end

  assign vout = v4_r;
  assign dout = d4_r;

endmodule

// ===== src/cache_block_word_mixer_core.sv =====
// ----------------------------------------------------------------------------
// cache_block_word_mixer_core
// Mixes eight root words and a block index into one 64-byte cache block.
// ----------------------------------------------------------------------------
// A new item is taken every cycle: busy stays low, so start alone accepts an
// item. Each result appears on out_data with out_valid high for one cycle, in
// order; the receiver cannot stall, so take it in that cycle. The pipeline is
// the tweak front end (3 stages) and a chain of 24 cells, one per word update
// of three rounds, each 4 stages deep around a split 64-bit constant multiply.
// Configuration writes are registered; write only while no item is in flight.
`timescale 1ns / 1ps

`include "cache_block_word_mixer_core_macros.svh"

module cache_block_word_mixer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cbwm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output cbwm_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  cbwm_pkg::cfg_idx_t   cfg_idx,
  input  cbwm_pkg::cfg_data_t  cfg_data
);
  import cbwm_pkg::*;

  localparam int unsigned CELLS     = ROUNDS * WORDS;
  localparam int unsigned CELL_LAT  = 4 * CELLS;
  localparam int unsigned FRONT_LAT = 3;
  localparam int unsigned LATENCY   = FRONT_LAT + CELL_LAT;

  logic [47:0] cache_r, dataset_r;
  logic [31:0] rounds_r, taps_r;
  word_t       bias;
  logic        accept;

  logic   node_v [CELLS+1];
  stage_t node_d [CELLS+1];

  // Hold configuration; writes take effect at the next edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_r   <= '0;
      dataset_r <= '0;
      rounds_r  <= '0;
      taps_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CACHE_BYTES:   cache_r   <= cfg_data;
        CFG_DATASET_BYTES: dataset_r <= cfg_data;
        CFG_ROUND_COUNT:   rounds_r  <= cfg_data[31:0];
        CFG_TAP_COUNT:     taps_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Fold the profile into one bias word.
  assign bias = {16'd0, cache_r} ^ {16'd0, dataset_r} ^ {rounds_r, 32'd0}
              ^ {32'd0, taps_r};

  // Fully pipelined: never refuse an item.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  cbwm_tweak u_tweak (
    .clk   (clk),
    .rst_n (rst_n),
    .vin   (accept),
    .din   (in_data),
    .bias  (bias),
    .vout  (node_v[0]),
    .dout  (node_d[0])
  );

  // Advance each item through the cells in model order: round-major, word-minor.
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    for (genvar i = 0; i < WORDS; i++) begin : g_word
      cbwm_cell #(
        .ROUND (r),
        .IDX   (i)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .vin   (node_v[r*WORDS+i]),
        .din   (node_d[r*WORDS+i]),
        .vout  (node_v[r*WORDS+i+1]),
        .dout  (node_d[r*WORDS+i+1])
      );
    end
  end

  // The last cell's stage register is the output register.
  assign out_valid           = node_v[CELLS];
  assign out_data.out_word_0 = node_d[CELLS].w[0];
  assign out_data.out_word_1 = node_d[CELLS].w[1];
  assign out_data.out_word_2 = node_d[CELLS].w[2];
  assign out_data.out_word_3 = node_d[CELLS].w[3];
  assign out_data.out_word_4 = node_d[CELLS].w[4];
  assign out_data.out_word_5 = node_d[CELLS].w[5];
  assign out_data.out_word_6 = node_d[CELLS].w[6];
  assign out_data.out_word_7 = node_d[CELLS].w[7];

  `CBWM_ASSERT(a_front_lat, node_v[0], $past(accept, FRONT_LAT), "tweak valid without item")
  `CBWM_ASSERT(a_chain_lat, out_valid, $past(node_v[0], CELL_LAT), "cell chain lost timing")
  `CBWM_ASSERT(a_total_lat, out_valid, $past(accept, LATENCY), "result without item")

endmodule
